### sv/tdpe_pkg.sv
// Package for the trial-division prime engine: widths, command and status codes,
// microcode op/condition types, the microprogram ROM and the command dispatch table.
// No dependencies.
package tdpe_pkg;

    localparam int WIDTH = 16;
    localparam int VAL_W = WIDTH + 1;
    localparam int IN_W  = 16;
    localparam int OUT_W = 17;
    localparam int CMD_W = 3;
    localparam int ST_W  = 2;
    localparam int CNT_W = $clog2(VAL_W);
    localparam int PC_W  = 6;

    localparam logic [VAL_W-1:0] MAX_VAL = (VAL_W'(1) << WIDTH) - VAL_W'(1);
    localparam logic [VAL_W-1:0] TWO     = VAL_W'(2);
    localparam logic [VAL_W-1:0] FOUR    = VAL_W'(4);

    localparam logic [CMD_W-1:0] CMD_DIVISIBLE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_IS_PRIME    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_NEXT_PRIME  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_COUNT       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_IS_TWIN     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_NEXT_TWIN   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_LARGEST_TWN = 3'd6;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_ZERO_DIV = 2'd1;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;
    localparam logic [ST_W-1:0] ST_NONE     = 2'd3;

    typedef logic [PC_W-1:0] t_pc;

    typedef struct packed {
        logic busy;
        logic zero;
    } t_rem_stat;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_PT_INIT, OP_D_INC, OP_DIV_ND, OP_DIV_AB, OP_FLAG_CLR,
        OP_N_A, OP_N_K, OP_N_KM2, OP_N_KP2, OP_K_A, OP_K_B, OP_K_INC, OP_K_DEC,
        OP_K_A_OVF, OP_ST_NONE, OP_ST_ZDIV, OP_TRUTH_REMZ, OP_TRUTH_FLAG,
        OP_VAL_K_OK, OP_CNT_FLAG, OP_OUT_LOAD
    } t_op;

    typedef enum logic [4:0] {
        C_NEXT, C_ALWAYS, C_NO_IN, C_DISPATCH, C_CALL_PT, C_RET_PT, C_CALL_TW,
        C_RET_TW, C_BUSY, C_N_LT2, C_SQ_GT_N, C_REM_ZERO, C_FLAG_CLR, C_FLAG_SET,
        C_K_LT4, C_K_GE_MAX, C_K_GT_B, C_K_LE_A, C_A_GT_B, C_B_ZERO, C_CMD_TWIN,
        C_OUT_FULL
    } t_cond;

    // op runs each step; if cond holds, jump to target or dispatch/ret pc, else pc+1
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // entry points and jump targets
    localparam t_pc A_IDLE      = 6'd0;
    localparam t_pc A_DISPATCH  = 6'd1;
    localparam t_pc A_FIN       = 6'd2;
    localparam t_pc A_PT        = 6'd4;
    localparam t_pc A_PT_LOOP   = 6'd5;
    localparam t_pc A_PT_WAIT   = 6'd7;
    localparam t_pc A_PT_NO     = 6'd10;
    localparam t_pc A_PT_YES    = 6'd11;
    localparam t_pc A_TW        = 6'd12;
    localparam t_pc A_TW_HI     = 6'd18;
    localparam t_pc A_TW_RET    = 6'd20;
    localparam t_pc A_DIV       = 6'd21;
    localparam t_pc A_DIV_WAIT  = 6'd23;
    localparam t_pc A_DIV_ZERO  = 6'd25;
    localparam t_pc A_ISP       = 6'd26;
    localparam t_pc A_IST       = 6'd29;
    localparam t_pc A_NXT       = 6'd32;
    localparam t_pc A_NXT_LOOP  = 6'd33;
    localparam t_pc A_NXT_OK    = 6'd38;
    localparam t_pc A_NXT_TW    = 6'd39;
    localparam t_pc A_CNT       = 6'd42;
    localparam t_pc A_CNT_LOOP  = 6'd43;
    localparam t_pc A_LTW       = 6'd48;
    localparam t_pc A_LTW_LOOP  = 6'd50;
    localparam t_pc A_LTW_OK    = 6'd54;

    function automatic t_uword mk(t_op op, t_cond cond, t_pc target);
        t_uword w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    function automatic t_uword ucode(t_pc addr);
        t_uword w;
        unique case (addr)
            // idle, dispatch, result handoff
            6'd0:  w = mk(OP_LOAD,       C_NO_IN,    A_IDLE);
            6'd1:  w = mk(OP_NOP,        C_DISPATCH, A_IDLE);
            6'd2:  w = mk(OP_OUT_LOAD,   C_OUT_FULL, A_FIN);
            6'd3:  w = mk(OP_NOP,        C_ALWAYS,   A_IDLE);
            // prime test on n, result in flag
            6'd4:  w = mk(OP_PT_INIT,    C_N_LT2,    A_PT_NO);
            6'd5:  w = mk(OP_NOP,        C_SQ_GT_N,  A_PT_YES);
            6'd6:  w = mk(OP_DIV_ND,     C_NEXT,     A_IDLE);
            6'd7:  w = mk(OP_NOP,        C_BUSY,     A_PT_WAIT);
            6'd8:  w = mk(OP_NOP,        C_REM_ZERO, A_PT_NO);
            6'd9:  w = mk(OP_D_INC,      C_ALWAYS,   A_PT_LOOP);
            6'd10: w = mk(OP_FLAG_CLR,   C_RET_PT,   A_IDLE);
            6'd11: w = mk(OP_NOP,        C_RET_PT,   A_IDLE);
            // twin test on k, result in flag
            6'd12: w = mk(OP_N_K,        C_NEXT,     A_IDLE);
            6'd13: w = mk(OP_NOP,        C_CALL_PT,  A_PT);
            6'd14: w = mk(OP_NOP,        C_FLAG_CLR, A_TW_RET);
            6'd15: w = mk(OP_N_KM2,      C_K_LT4,    A_TW_HI);
            6'd16: w = mk(OP_NOP,        C_CALL_PT,  A_PT);
            6'd17: w = mk(OP_NOP,        C_FLAG_SET, A_TW_RET);
            6'd18: w = mk(OP_N_KP2,      C_NEXT,     A_IDLE);
            6'd19: w = mk(OP_NOP,        C_CALL_PT,  A_PT);
            6'd20: w = mk(OP_NOP,        C_RET_TW,   A_IDLE);
            // divisible
            6'd21: w = mk(OP_NOP,        C_B_ZERO,   A_DIV_ZERO);
            6'd22: w = mk(OP_DIV_AB,     C_NEXT,     A_IDLE);
            6'd23: w = mk(OP_NOP,        C_BUSY,     A_DIV_WAIT);
            6'd24: w = mk(OP_TRUTH_REMZ, C_ALWAYS,   A_FIN);
            6'd25: w = mk(OP_ST_ZDIV,    C_ALWAYS,   A_FIN);
            // is_prime
            6'd26: w = mk(OP_N_A,        C_NEXT,     A_IDLE);
            6'd27: w = mk(OP_NOP,        C_CALL_PT,  A_PT);
            6'd28: w = mk(OP_TRUTH_FLAG, C_ALWAYS,   A_FIN);
            // is_twin
            6'd29: w = mk(OP_K_A,        C_NEXT,     A_IDLE);
            6'd30: w = mk(OP_NOP,        C_CALL_TW,  A_TW);
            6'd31: w = mk(OP_TRUTH_FLAG, C_ALWAYS,   A_FIN);
            // next prime / next twin
            6'd32: w = mk(OP_K_A_OVF,    C_NEXT,     A_IDLE);
            6'd33: w = mk(OP_NOP,        C_K_GE_MAX, A_FIN);
            6'd34: w = mk(OP_K_INC,      C_NEXT,     A_IDLE);
            6'd35: w = mk(OP_N_K,        C_CMD_TWIN, A_NXT_TW);
            6'd36: w = mk(OP_NOP,        C_CALL_PT,  A_PT);
            6'd37: w = mk(OP_NOP,        C_FLAG_CLR, A_NXT_LOOP);
            6'd38: w = mk(OP_VAL_K_OK,   C_ALWAYS,   A_FIN);
            6'd39: w = mk(OP_NOP,        C_CALL_TW,  A_TW);
            6'd40: w = mk(OP_NOP,        C_FLAG_CLR, A_NXT_LOOP);
            6'd41: w = mk(OP_NOP,        C_ALWAYS,   A_NXT_OK);
            // count primes in [a, b]
            6'd42: w = mk(OP_K_A,        C_NEXT,     A_IDLE);
            6'd43: w = mk(OP_NOP,        C_K_GT_B,   A_FIN);
            6'd44: w = mk(OP_N_K,        C_NEXT,     A_IDLE);
            6'd45: w = mk(OP_NOP,        C_CALL_PT,  A_PT);
            6'd46: w = mk(OP_CNT_FLAG,   C_NEXT,     A_IDLE);
            6'd47: w = mk(OP_K_INC,      C_ALWAYS,   A_CNT_LOOP);
            // largest twin in [a, b], scanning down from b
            6'd48: w = mk(OP_ST_NONE,    C_A_GT_B,   A_FIN);
            6'd49: w = mk(OP_K_B,        C_NEXT,     A_IDLE);
            6'd50: w = mk(OP_NOP,        C_CALL_TW,  A_TW);
            6'd51: w = mk(OP_NOP,        C_FLAG_SET, A_LTW_OK);
            6'd52: w = mk(OP_NOP,        C_K_LE_A,   A_FIN);
            6'd53: w = mk(OP_K_DEC,      C_ALWAYS,   A_LTW_LOOP);
            6'd54: w = mk(OP_VAL_K_OK,   C_ALWAYS,   A_FIN);
            default: w = mk(OP_NOP,      C_ALWAYS,   A_IDLE);
        endcase
        return w;
    endfunction

    function automatic t_pc dispatch(logic [CMD_W-1:0] cmd);
        t_pc a;
        unique case (cmd)
            CMD_DIVISIBLE:   a = A_DIV;
            CMD_IS_PRIME:    a = A_ISP;
            CMD_NEXT_PRIME:  a = A_NXT;
            CMD_COUNT:       a = A_CNT;
            CMD_IS_TWIN:     a = A_IST;
            CMD_NEXT_TWIN:   a = A_NXT;
            CMD_LARGEST_TWN: a = A_LTW;
            default:         a = A_FIN;
        endcase
        return a;
    endfunction

endpackage

### sv/tdpe_cmd_if.sv
// Command channel: valid/ready handshake with command code and two operands.
// Depends on tdpe_pkg.
interface tdpe_cmd_if;
    import tdpe_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [IN_W-1:0]  first_value;
    logic [IN_W-1:0]  second_value;

    modport source (output valid, output cmd, output first_value, output second_value,
                    input ready);
    modport sink   (input valid, input cmd, input first_value, input second_value,
                    output ready);
endinterface

### sv/tdpe_res_if.sv
// Result channel: valid/ready handshake with truth, value and status.
// Depends on tdpe_pkg.
interface tdpe_res_if;
    import tdpe_pkg::*;

    logic             valid;
    logic             ready;
    logic             truth;
    logic [OUT_W-1:0] value;
    logic [ST_W-1:0]  status;

    modport source (output valid, output truth, output value, output status, input ready);
    modport sink   (input valid, input truth, input value, input status, output ready);
endinterface

### sv/tdpe_rem.sv
// Bit-serial restoring remainder unit, one quotient bit per cycle.
// Depends on tdpe_pkg.
module tdpe_rem (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [tdpe_pkg::VAL_W-1:0] i_dividend,
    input  logic [tdpe_pkg::VAL_W-1:0] i_divisor,
    output tdpe_pkg::t_rem_stat        o_stat
);
    import tdpe_pkg::*;

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [VAL_W-1:0] r_rem;
    logic [VAL_W-1:0] r_dvd;
    logic [VAL_W-1:0] r_dsr;

    logic [VAL_W:0]   rem_sh;
    logic [VAL_W:0]   diff;
    logic [VAL_W-1:0] n_rem;

    always_comb begin
        rem_sh = {r_rem, r_dvd[VAL_W-1]};
        diff   = rem_sh - {1'b0, r_dsr};
        n_rem  = (rem_sh >= {1'b0, r_dsr}) ? diff[VAL_W-1:0] : rem_sh[VAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CNT_W'(VAL_W - 1);
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            r_rem <= n_rem;
            r_dvd <= {r_dvd[VAL_W-2:0], 1'b0};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.zero = (r_rem == '0);

endmodule

### sv/trial_division_prime_engine.sv
// Trial-division prime engine: microcoded sequencer over a small datapath and a
// shared bit-serial remainder unit; one command in, one result out.
// A prime test on n tries divisors d = 2, 3, ... while d*d <= n, stopping at the first
// zero remainder. Searches and counts repeat it per candidate.
// One command at a time; a new command is taken once the result sits in the output
// register. Synchronous active-low reset returns the sequencer to idle, output empty.
module trial_division_prime_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tdpe_cmd_if.sink   i_cmd,
    tdpe_res_if.source o_res
);
    import tdpe_pkg::*;

    t_uword           uw;
    logic             accept;
    logic             out_full;
    logic             take;
    t_rem_stat        rem_stat;
    logic             rem_start;
    logic [VAL_W-1:0] rem_dividend;
    logic [VAL_W-1:0] rem_divisor;

    t_pc              r_pc, n_pc;
    t_pc              r_ret_pt, n_ret_pt;
    t_pc              r_ret_tw, n_ret_tw;
    logic             r_o_valid, n_o_valid;

    logic [CMD_W-1:0] r_cmd, n_cmd;
    logic [VAL_W-1:0] r_a, n_a;
    logic [VAL_W-1:0] r_b, n_b;
    logic [VAL_W-1:0] r_k, n_k;
    logic [VAL_W-1:0] r_n, n_n;
    logic [VAL_W-1:0] r_d, n_d;
    logic [VAL_W-1:0] r_sq, n_sq;
    logic             r_flag, n_flag;
    logic             r_truth, n_truth;
    logic [VAL_W-1:0] r_val, n_val;
    logic [ST_W-1:0]  r_st, n_st;
    logic             r_o_truth, n_o_truth;
    logic [OUT_W-1:0] r_o_value, n_o_value;
    logic [ST_W-1:0]  r_o_status, n_o_status;

    assign uw       = ucode(r_pc);
    assign accept   = i_cmd.valid && i_cmd.ready;
    assign out_full = r_o_valid && !o_res.ready;

    assign i_cmd.ready  = (r_pc == A_IDLE);
    assign o_res.valid  = r_o_valid;
    assign o_res.truth  = r_o_truth;
    assign o_res.value  = r_o_value;
    assign o_res.status = r_o_status;

    assign rem_start    = (uw.op == OP_DIV_ND) || (uw.op == OP_DIV_AB);
    assign rem_dividend = (uw.op == OP_DIV_AB) ? r_a : r_n;
    assign rem_divisor  = (uw.op == OP_DIV_AB) ? r_b : r_d;

    tdpe_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (rem_dividend),
        .i_divisor  (rem_divisor),
        .o_stat     (rem_stat)
    );

    // jump condition
    always_comb begin
        unique case (uw.cond)
            C_NEXT:     take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_IN:    take = !accept;
            C_DISPATCH: take = 1'b1;
            C_CALL_PT:  take = 1'b1;
            C_RET_PT:   take = 1'b1;
            C_CALL_TW:  take = 1'b1;
            C_RET_TW:   take = 1'b1;
            C_BUSY:     take = rem_stat.busy;
            C_N_LT2:    take = (r_n < TWO);
            C_SQ_GT_N:  take = (r_sq > r_n);
            C_REM_ZERO: take = rem_stat.zero;
            C_FLAG_CLR: take = !r_flag;
            C_FLAG_SET: take = r_flag;
            C_K_LT4:    take = (r_k < FOUR);
            C_K_GE_MAX: take = (r_k >= MAX_VAL);
            C_K_GT_B:   take = (r_k > r_b);
            C_K_LE_A:   take = (r_k <= r_a);
            C_A_GT_B:   take = (r_a > r_b);
            C_B_ZERO:   take = (r_b == '0);
            C_CMD_TWIN: take = (r_cmd == CMD_NEXT_TWIN);
            C_OUT_FULL: take = out_full;
            default:    take = 1'b1;
        endcase
    end

    // sequencer
    always_comb begin
        n_ret_pt = r_ret_pt;
        n_ret_tw = r_ret_tw;
        n_pc     = take ? uw.target : r_pc + t_pc'(1);
        unique case (uw.cond)
            C_DISPATCH: n_pc = dispatch(r_cmd);
            C_CALL_PT:  n_ret_pt = r_pc + t_pc'(1);
            C_CALL_TW:  n_ret_tw = r_pc + t_pc'(1);
            C_RET_PT:   n_pc = r_ret_pt;
            C_RET_TW:   n_pc = r_ret_tw;
            default:    ;
        endcase
    end

    // datapath
    always_comb begin
        n_cmd      = r_cmd;
        n_a        = r_a;
        n_b        = r_b;
        n_k        = r_k;
        n_n        = r_n;
        n_d        = r_d;
        n_sq       = r_sq;
        n_flag     = r_flag;
        n_truth    = r_truth;
        n_val      = r_val;
        n_st       = r_st;
        n_o_truth  = r_o_truth;
        n_o_value  = r_o_value;
        n_o_status = r_o_status;
        n_o_valid  = r_o_valid && !o_res.ready;
        unique case (uw.op)
            OP_LOAD: begin
                if (accept) begin
                    n_cmd   = i_cmd.cmd;
                    n_a     = VAL_W'(i_cmd.first_value) & MAX_VAL;
                    n_b     = VAL_W'(i_cmd.second_value) & MAX_VAL;
                    n_truth = 1'b0;
                    n_val   = '0;
                    n_st    = ST_OK;
                end
            end
            OP_PT_INIT: begin
                n_d    = TWO;
                n_sq   = FOUR;
                n_flag = 1'b1;
            end
            // (d+1)^2 = d^2 + 2d + 1
            OP_D_INC: begin
                n_d  = r_d + VAL_W'(1);
                n_sq = r_sq + {r_d[VAL_W-2:0], 1'b1};
            end
            OP_FLAG_CLR:   n_flag = 1'b0;
            OP_N_A:        n_n = r_a;
            OP_N_K:        n_n = r_k;
            OP_N_KM2:      n_n = r_k - TWO;
            OP_N_KP2:      n_n = r_k + TWO;
            OP_K_A:        n_k = r_a;
            OP_K_B:        n_k = r_b;
            OP_K_INC:      n_k = r_k + VAL_W'(1);
            OP_K_DEC:      n_k = r_k - VAL_W'(1);
            OP_K_A_OVF: begin
                n_k  = r_a;
                n_st = ST_OVERFLOW;
            end
            OP_ST_NONE:    n_st = ST_NONE;
            OP_ST_ZDIV:    n_st = ST_ZERO_DIV;
            OP_TRUTH_REMZ: n_truth = rem_stat.zero;
            OP_TRUTH_FLAG: n_truth = r_flag;
            OP_VAL_K_OK: begin
                n_val = r_k;
                n_st  = ST_OK;
            end
            OP_CNT_FLAG:   n_val = r_val + VAL_W'(r_flag);
            OP_OUT_LOAD: begin
                if (!out_full) begin
                    n_o_valid  = 1'b1;
                    n_o_truth  = r_truth;
                    n_o_value  = OUT_W'(r_val);
                    n_o_status = r_st;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= A_IDLE;
            r_ret_pt  <= A_IDLE;
            r_ret_tw  <= A_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_pc      <= n_pc;
            r_ret_pt  <= n_ret_pt;
            r_ret_tw  <= n_ret_tw;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_a        <= n_a;
        r_b        <= n_b;
        r_k        <= n_k;
        r_n        <= n_n;
        r_d        <= n_d;
        r_sq       <= n_sq;
        r_flag     <= n_flag;
        r_truth    <= n_truth;
        r_val      <= n_val;
        r_st       <= n_st;
        r_o_truth  <= n_o_truth;
        r_o_value  <= n_o_value;
        r_o_status <= n_o_status;
    end

    // a command transaction always moves the sequencer to dispatch
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_pc == A_DISPATCH))
        else $error("sequencer did not dispatch after command transaction");

    // the remainder unit is never restarted mid-division
    a_rem_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_start |-> !rem_stat.busy)
        else $error("remainder unit started while busy");

    // a zero-divisor result carries no answer
    a_zero_div_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status == ST_ZERO_DIV) |-> (!r_o_truth && r_o_value == '0))
        else $error("zero-divisor result with nonzero payload");

    // a new result is loaded only into an empty or draining output register
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.op == OP_OUT_LOAD && r_o_valid && !o_res.ready) |=> (r_pc == A_FIN))
        else $error("sequencer left handoff step while output stalled");

endmodule

### bench/trial_division_prime_engine_tb.sv
// Testbench for trial_division_prime_engine: directed and random commands, in-bench
// trial-division predictor, per-field result checks under sender gaps and receiver stalls.
// Depends on tdpe_pkg, tdpe_cmd_if, tdpe_res_if and the engine RTL.
module trial_division_prime_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tdpe_pkg::*;

    // cmd code 7 has no package name; the engine answers it with an all-zero result
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    localparam int unsigned TOP_VAL = 65535;

    typedef struct {
        logic [CMD_W-1:0] op;
        logic [IN_W-1:0]  a;
        logic [IN_W-1:0]  b;
    } t_prime_cmd;

    typedef struct {
        logic             truth;
        logic [OUT_W-1:0] value;
        logic [ST_W-1:0]  status;
    } t_prime_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tdpe_cmd_if cmd_bus();
    tdpe_res_if res_bus();

    trial_division_prime_engine i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    t_prime_cmd    cmd_backlog[$];
    t_prime_answer answers_due[$];
    t_prime_cmd    next_cmd;
    t_prime_answer got_answer;
    t_prime_answer want_answer;

    int     issued = 0;
    int     taken = 0;
    int     mismatches = 0;
    int     burst_left = 1;
    int     gap_left = 0;
    int     stall_left = 0;
    int     stall_mode = 0;
    longint planned_effort = 0;
    longint scratch_effort = 0;
    longint cycle_count = 0;
    longint cycle_limit = 64'h3fff_ffff_ffff_ffff;

    always #1 i_clk = ~i_clk;

    // effort is a rough cycle estimate, used only to size the timeout
    function automatic bit trial_prime(int unsigned n, inout longint effort);
        int unsigned d;
        effort += 20;
        if (n < 2) return 1'b0;
        for (d = 2; d * d <= n; d++) begin
            effort += 30;
            if (n % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit twin_member(int unsigned n, inout longint effort);
        if (!trial_prime(n, effort)) return 1'b0;
        // lower neighbor below 2 never counts
        if (n >= 4 && trial_prime(n - 2, effort)) return 1'b1;
        return trial_prime(n + 2, effort);
    endfunction

    function automatic t_prime_answer compute_answer(logic [CMD_W-1:0] op,
                                                     logic [IN_W-1:0] a_in,
                                                     logic [IN_W-1:0] b_in,
                                                     inout longint effort);
        t_prime_answer r;
        int unsigned   a;
        int unsigned   b;
        int unsigned   k;
        int unsigned   tally;
        int unsigned   top;
        bit            hit;
        r.truth  = 1'b0;
        r.value  = '0;
        r.status = ST_OK;
        a = 32'(a_in);
        b = 32'(b_in);
        tally = 0;
        top = 32'(MAX_VAL);
        case (op)
            CMD_DIVISIBLE: begin
                effort += 30;
                if (b == 0) r.status = ST_ZERO_DIV;
                else r.truth = (a % b == 0);
            end
            CMD_IS_PRIME: r.truth = trial_prime(a, effort);
            CMD_IS_TWIN:  r.truth = twin_member(a, effort);
            CMD_NEXT_PRIME, CMD_NEXT_TWIN: begin
                r.status = ST_OVERFLOW;
                k = a;
                while (k < top && r.status == ST_OVERFLOW) begin
                    k++;
                    hit = (op == CMD_NEXT_PRIME) ? trial_prime(k, effort)
                                                 : twin_member(k, effort);
                    if (hit) begin
                        r.value  = OUT_W'(k);
                        r.status = ST_OK;
                    end
                end
            end
            CMD_COUNT: begin
                for (k = a; k <= b; k++) begin
                    if (trial_prime(k, effort)) tally++;
                end
                r.value = OUT_W'(tally);
            end
            CMD_LARGEST_TWN: begin
                r.status = ST_NONE;
                if (a <= b) begin
                    k = b + 1;
                    while (k > a && r.status == ST_NONE) begin
                        k--;
                        if (twin_member(k, effort)) begin
                            r.value  = OUT_W'(k);
                            r.status = ST_OK;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic queue_cmd(logic [CMD_W-1:0] op, int unsigned a, int unsigned b);
        t_prime_cmd    c;
        t_prime_answer dummy;
        c.op = op;
        c.a  = IN_W'(a);
        c.b  = IN_W'(b);
        cmd_backlog.push_back(c);
        dummy = compute_answer(c.op, c.a, c.b, planned_effort);
    endtask

    // mostly small operands keep the trial-division loops short
    function automatic int unsigned pick_operand();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 15);
            1, 2:    return $urandom_range(0, 1023);
            3:       return $urandom_range(0, 8191);
            default: return $urandom & 16'hffff;
        endcase
    endfunction

    // sender: bursts of transactions separated by random gaps
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!cmd_bus.valid || taken == issued) begin
                if (gap_left > 0 || cmd_backlog.size() == 0) begin
                    cmd_bus.valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end else begin
                    next_cmd = cmd_backlog.pop_front();
                    cmd_bus.valid        <= 1'b1;
                    cmd_bus.cmd          <= next_cmd.op;
                    cmd_bus.first_value  <= next_cmd.a;
                    cmd_bus.second_value <= next_cmd.b;
                    issued++;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 8);
                        case ($urandom_range(0, 3))
                            0:       gap_left = 0;
                            1, 2:    gap_left = $urandom_range(1, 20);
                            default: gap_left = $urandom_range(100, 3000);
                        endcase
                    end
                end
            end
        end
    end

    // receiver: randomly chosen stretches of always-ready, random and mostly-stalled
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(1, 200);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0:       res_bus.ready <= 1'b1;
            1:       res_bus.ready <= 1'($urandom_range(0, 1));
            default: res_bus.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cmd_bus.valid && cmd_bus.ready) begin
                answers_due.push_back(compute_answer(cmd_bus.cmd, cmd_bus.first_value,
                                                     cmd_bus.second_value, scratch_effort));
                taken++;
            end
            if (res_bus.valid && res_bus.ready) begin
                got_answer.truth  = res_bus.truth;
                got_answer.value  = res_bus.value;
                got_answer.status = res_bus.status;
                if (answers_due.size() == 0) begin
                    $error("result transaction with nothing outstanding: %s %0b %0d %0d",
                           "truth value status", got_answer.truth, got_answer.value,
                           got_answer.status);
                    mismatches++;
                end else begin
                    want_answer = answers_due.pop_front();
                    if (got_answer.truth !== want_answer.truth) begin
                        $error("truth: expected %0b, got %0b",
                               want_answer.truth, got_answer.truth);
                        mismatches++;
                    end
                    if (got_answer.value !== want_answer.value) begin
                        $error("value: expected %0d, got %0d",
                               want_answer.value, got_answer.value);
                        mismatches++;
                    end
                    if (got_answer.status !== want_answer.status) begin
                        $error("status: expected %0d, got %0d",
                               want_answer.status, got_answer.status);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > cycle_limit) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int unsigned a;
        int unsigned b;
        int unsigned span;
        int unsigned op_pick;
        logic [CMD_W-1:0] op;

        cmd_bus.valid        = 1'b0;
        cmd_bus.cmd          = CMD_DIVISIBLE;
        cmd_bus.first_value  = '0;
        cmd_bus.second_value = '0;
        res_bus.ready        = 1'b0;

        // directed: operand extremes, every command, small numbers, zero divisor,
        // search overflow, reversed and twin-free ranges, unused command code
        queue_cmd(CMD_DIVISIBLE, TOP_VAL, TOP_VAL);
        queue_cmd(CMD_DIVISIBLE, 0, 0);
        queue_cmd(CMD_DIVISIBLE, TOP_VAL, 0);
        queue_cmd(CMD_DIVISIBLE, 12345, 5);
        queue_cmd(CMD_IS_PRIME, 0, 0);
        queue_cmd(CMD_IS_PRIME, 1, 0);
        queue_cmd(CMD_IS_PRIME, 2, 0);
        queue_cmd(CMD_IS_PRIME, 65521, 0);
        queue_cmd(CMD_IS_PRIME, TOP_VAL, TOP_VAL);
        queue_cmd(CMD_NEXT_PRIME, 0, 0);
        queue_cmd(CMD_NEXT_PRIME, 65520, 0);
        queue_cmd(CMD_NEXT_PRIME, 65521, 0);
        queue_cmd(CMD_NEXT_PRIME, TOP_VAL, 0);
        queue_cmd(CMD_COUNT, 0, 100);
        queue_cmd(CMD_COUNT, 100, 0);
        queue_cmd(CMD_COUNT, 65500, TOP_VAL);
        queue_cmd(CMD_IS_TWIN, 2, 0);
        queue_cmd(CMD_IS_TWIN, 3, 0);
        queue_cmd(CMD_IS_TWIN, 65521, 0);
        queue_cmd(CMD_NEXT_TWIN, 0, 0);
        queue_cmd(CMD_NEXT_TWIN, 65521, 0);
        queue_cmd(CMD_LARGEST_TWN, 0, TOP_VAL);
        queue_cmd(CMD_LARGEST_TWN, 100, 0);
        queue_cmd(CMD_LARGEST_TWN, 24, 28);
        queue_cmd(CMD_UNUSED, TOP_VAL, TOP_VAL);

        repeat (115) begin
            op_pick = $urandom_range(0, 7);
            if (op_pick == 7 && $urandom_range(0, 2) != 0) op_pick = $urandom_range(0, 6);
            op = CMD_W'(op_pick);
            a = $urandom & 16'hffff;
            b = $urandom & 16'hffff;
            case (op)
                CMD_DIVISIBLE: begin
                    case ($urandom_range(0, 9))
                        0:       b = 0;
                        1, 2, 3: b = $urandom_range(1, 16);
                        4, 5: begin
                            b = $urandom_range(1, 255);
                            a = b * $urandom_range(0, TOP_VAL / b);
                        end
                        default: ;
                    endcase
                end
                CMD_IS_PRIME, CMD_IS_TWIN: begin
                    if ($urandom_range(0, 1) == 0) a = $urandom_range(0, 300);
                end
                CMD_NEXT_PRIME: begin
                    a = ($urandom_range(0, 9) == 0) ? $urandom_range(65500, TOP_VAL)
                                                    : pick_operand();
                end
                CMD_COUNT: begin
                    a = pick_operand();
                    span = (a < 2048) ? $urandom_range(0, 400) : $urandom_range(0, 48);
                    b = (a + span > TOP_VAL) ? TOP_VAL : a + span;
                    if ($urandom_range(0, 7) == 0) begin
                        span = a;
                        a = b;
                        b = (span == 0) ? 0 : span - 1;
                    end
                end
                CMD_NEXT_TWIN: begin
                    a = ($urandom_range(0, 5) == 0) ? ($urandom & 16'hffff)
                                                    : $urandom_range(0, 4095);
                end
                CMD_LARGEST_TWN: begin
                    b = ($urandom_range(0, 5) == 0) ? ($urandom & 16'hffff)
                                                    : $urandom_range(0, 4095);
                    span = $urandom_range(0, 256);
                    a = (span > b) ? 0 : b - span;
                    // reversed range
                    if ($urandom_range(0, 7) == 0) begin
                        a = b + $urandom_range(1, 1000);
                        if (a > TOP_VAL) a = TOP_VAL;
                    end
                end
                default: ;
            endcase
            queue_cmd(op, a, b);
        end

        cycle_limit = 4 * planned_effort + 16000 * longint'(cmd_backlog.size()) + 20000;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || taken != issued) @(negedge i_clk);
        while (answers_due.size() != 0) @(negedge i_clk);
        // catch any extra result transaction
        repeat (64) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### filelist.f
sv/tdpe_pkg.sv
sv/tdpe_cmd_if.sv
sv/tdpe_res_if.sv
sv/tdpe_rem.sv
sv/trial_division_prime_engine.sv
bench/trial_division_prime_engine_tb.sv
